FILE: src/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg: shared definitions for the state variable filter
// widths, register indexes, microcode word layout and the control program
// ----------------------------------------------------------------------------
package svf_pkg;

	// field and arithmetic widths
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int STATE_BITS     = 32;
	localparam int GUARD_BITS     = 8;

	localparam int FREQ_W     = 18;
	localparam int DAMP_W     = 17;
	localparam int SCALE_W    = 17;
	localparam int MODE_W     = 2;
	localparam int COEF_W     = 18;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 2;

	// product of a state magnitude and a coefficient, and its rounded result
	localparam int PROD_W = STATE_BITS + COEF_W;
	localparam int MRES_W = PROD_W - COEF_FRAC_BITS;
	// sum of three products / states never leaves this range
	localparam int ACC_W  = MRES_W + 3;
	// rounded output magnitude
	localparam int RND_W  = STATE_BITS + 1 - GUARD_BITS;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	// register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_FREQ  = 2'd0;
	localparam cfg_idx_t REG_DAMP  = 2'd1;
	localparam cfg_idx_t REG_SCALE = 2'd2;
	localparam cfg_idx_t REG_MODE  = 2'd3;

	localparam logic [FREQ_W-1:0]  FREQ_RESET  = 18'd4288;
	localparam logic [DAMP_W-1:0]  DAMP_RESET  = 17'd65536;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd65536;

	// response select codes
	localparam logic [MODE_W-1:0] MODE_LP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HP    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOTCH = 2'd3;

	// program steps
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_WAIT  = 3'd0;
	localparam step_t STEP_LOW   = 3'd1;
	localparam step_t STEP_HP_A  = 3'd2;
	localparam step_t STEP_HP_B  = 3'd3;
	localparam step_t STEP_NOTCH = 3'd4;
	localparam step_t STEP_BAND  = 3'd5;
	localparam step_t STEP_OUT   = 3'd6;

	typedef enum logic [1:0] {MA_BAND, MA_X, MA_HP} mul_a_t;
	typedef enum logic [1:0] {MC_FREQ, MC_DAMP, MC_SCALE} mul_c_t;
	typedef enum logic [2:0] {AA_LOW, AA_MUL, AA_ACC, AA_HP, AA_BAND} alu_a_t;
	typedef enum logic {AB_MUL, AB_LOW} alu_b_t;
	typedef enum logic [2:0] {DST_NONE, DST_LOW, DST_ACC, DST_HP, DST_NT, DST_BAND} dest_t;
	typedef enum logic [1:0] {CND_NONE, CND_IN, CND_OUT} cond_t;

	typedef struct packed {
		mul_a_t mul_a;
		mul_c_t mul_c;
		alu_a_t alu_a;
		alu_b_t alu_b;
		logic   alu_sub;
		dest_t  dest;
		logic   out_load;
		cond_t  cond;
		step_t  next_step;
	} ucode_t;

	// control store, one word per step
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w.mul_a     = MA_BAND;
		w.mul_c     = MC_FREQ;
		w.alu_a     = AA_LOW;
		w.alu_b     = AB_MUL;
		w.alu_sub   = 1'b0;
		w.dest      = DST_NONE;
		w.out_load  = 1'b0;
		w.cond      = CND_NONE;
		w.next_step = STEP_WAIT;
		case (step)
			STEP_WAIT: begin
				// band * freq runs while waiting for an item
				w.cond      = CND_IN;
				w.next_step = STEP_LOW;
			end
			STEP_LOW: begin
				// low = sat(low + M(band, f)), start M(x, s)
				w.mul_a     = MA_X;
				w.mul_c     = MC_SCALE;
				w.dest      = DST_LOW;
				w.next_step = STEP_HP_A;
			end
			STEP_HP_A: begin
				// acc = M(x, s) - lp, start M(band, q)
				w.mul_c     = MC_DAMP;
				w.alu_a     = AA_MUL;
				w.alu_b     = AB_LOW;
				w.alu_sub   = 1'b1;
				w.dest      = DST_ACC;
				w.next_step = STEP_HP_B;
			end
			STEP_HP_B: begin
				// hp = sat(acc - M(band, q))
				w.alu_a     = AA_ACC;
				w.alu_sub   = 1'b1;
				w.dest      = DST_HP;
				w.next_step = STEP_NOTCH;
			end
			STEP_NOTCH: begin
				// notch = sat(hp + lp), start M(hp, f)
				w.mul_a     = MA_HP;
				w.alu_a     = AA_HP;
				w.alu_b     = AB_LOW;
				w.dest      = DST_NT;
				w.next_step = STEP_BAND;
			end
			STEP_BAND: begin
				// band = sat(band + M(hp, f))
				w.alu_a     = AA_BAND;
				w.dest      = DST_BAND;
				w.next_step = STEP_OUT;
			end
			STEP_OUT: begin
				w.out_load  = 1'b1;
				w.cond      = CND_OUT;
				w.next_step = STEP_WAIT;
			end
			default: begin
				w.next_step = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: src/svf_in_if.sv
// ----------------------------------------------------------------------------
// svf_in_if: input sample channel
// valid/ready handshake carrying one audio sample per item
// ----------------------------------------------------------------------------
interface svf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: src/svf_out_if.sv
// ----------------------------------------------------------------------------
// svf_out_if: output sample channel
// valid/ready handshake carrying one filtered sample per item
// ----------------------------------------------------------------------------
interface svf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: src/state_variable_filter.sv
// ----------------------------------------------------------------------------
// state_variable_filter: fixed-point chamberlin state variable filter
// one multiplier and one adder, sequenced by a small microcode program
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                        handshake
//  in_ch     sink       sample_in  (s16, q1.15)        valid/ready
//  out_ch    source     sample_out (s16, q1.15)        valid/ready
//  cfg       write      cfg_idx, cfg_data (18 bits)    cfg_we
//
// an item runs a 7-step program: the wait step that accepts it, then six
// work steps that end in the output register, and a new item is taken
// only once the program is back at its wait step: four multiplies
// through the single multiplier, each registered and consumed by the
// add in the next step, set the program length
// the output register frees the input side: the next item is taken while
// a result waits, and the program only stalls on its last step when the
// previous result has still not been taken
// reset clears the states, the program counter and the output valid
//
module state_variable_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	svf_in_if.sink                              in_ch,
	svf_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  svf_pkg::cfg_idx_t                   cfg_idx,
	input  logic [svf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration registers
	logic [svf_pkg::FREQ_W-1:0]  freq_q;
	logic [svf_pkg::DAMP_W-1:0]  damp_q;
	logic [svf_pkg::SCALE_W-1:0] scale_q;
	logic [svf_pkg::MODE_W-1:0]  mode_q;

	// sequencer
	svf_pkg::step_t  step_q;
	svf_pkg::ucode_t uc;
	logic            advance;
	logic            in_acc;
	logic            out_acc;

	// filter state and scratch registers
	logic signed [svf_pkg::SAMPLE_BITS-1:0] x_q;
	logic signed [svf_pkg::STATE_BITS-1:0]  low_q;
	logic signed [svf_pkg::STATE_BITS-1:0]  band_q;
	logic signed [svf_pkg::STATE_BITS-1:0]  hp_q;
	logic signed [svf_pkg::STATE_BITS-1:0]  nt_q;
	logic signed [svf_pkg::ACC_W-1:0]       acc_q;

	// multiplier stage
	logic signed [svf_pkg::STATE_BITS-1:0] x_ext;
	logic signed [svf_pkg::STATE_BITS-1:0] mul_a;
	logic [svf_pkg::COEF_W-1:0]            mul_c;
	logic                                  mul_neg;
	logic [svf_pkg::STATE_BITS-1:0]        mul_mag;
	logic [svf_pkg::PROD_W-1:0]            mul_prod;
	logic [svf_pkg::MRES_W-1:0]            mres_q;
	logic                                  mneg_q;

	// adder stage
	logic signed [svf_pkg::ACC_W-1:0]      m_val;
	logic signed [svf_pkg::ACC_W-1:0]      alu_a;
	logic signed [svf_pkg::ACC_W-1:0]      alu_b;
	logic signed [svf_pkg::ACC_W-1:0]      alu_sum;
	logic signed [svf_pkg::STATE_BITS-1:0] alu_sat;

	// output rounding
	logic signed [svf_pkg::STATE_BITS-1:0]  sel_v;
	logic                                   sel_neg;
	logic [svf_pkg::STATE_BITS-1:0]         sel_mag;
	logic [svf_pkg::STATE_BITS:0]           rnd_sum;
	logic [svf_pkg::RND_W-1:0]              rnd;
	logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_d;
	logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                                   out_valid_q;

	localparam logic [svf_pkg::PROD_W-1:0] MUL_HALF =
		svf_pkg::PROD_W'(1) << (svf_pkg::COEF_FRAC_BITS - 1);
	localparam logic [svf_pkg::STATE_BITS:0] OUT_HALF =
		(svf_pkg::STATE_BITS + 1)'(1) << (svf_pkg::GUARD_BITS - 1);
	localparam logic [svf_pkg::RND_W-1:0] SMP_LIM =
		svf_pkg::RND_W'(1) << (svf_pkg::SAMPLE_BITS - 1);
	localparam logic signed [svf_pkg::SAMPLE_BITS-1:0] SMP_MIN =
		{1'b1, {(svf_pkg::SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [svf_pkg::SAMPLE_BITS-1:0] SMP_MAX = ~SMP_MIN;

	// ------------------------------------------------------------------
	// sequencer: fetch the control word, wait on the step's condition
	// ------------------------------------------------------------------
	assign uc = svf_pkg::ucode_rom(step_q);

	always_comb begin
		case (uc.cond)
			svf_pkg::CND_NONE: advance = 1'b1;
			svf_pkg::CND_IN:   advance = in_ch.valid;
			svf_pkg::CND_OUT:  advance = !out_valid_q || out_ch.ready;
			default:           advance = 1'b1;
		endcase
	end

	assign in_ch.ready = (uc.cond == svf_pkg::CND_IN);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_valid_q && out_ch.ready;

	// ------------------------------------------------------------------
	// multiplier: magnitude times coefficient, rounded half away from zero
	// ------------------------------------------------------------------
	// sample placed above the guard bits
	assign x_ext = {{(svf_pkg::STATE_BITS-svf_pkg::SAMPLE_BITS-svf_pkg::GUARD_BITS)
		{x_q[svf_pkg::SAMPLE_BITS-1]}}, x_q, {svf_pkg::GUARD_BITS{1'b0}}};

	always_comb begin
		case (uc.mul_a)
			svf_pkg::MA_BAND: mul_a = band_q;
			svf_pkg::MA_X:    mul_a = x_ext;
			svf_pkg::MA_HP:   mul_a = hp_q;
			default:          mul_a = band_q;
		endcase
		case (uc.mul_c)
			svf_pkg::MC_FREQ:  mul_c = freq_q;
			svf_pkg::MC_DAMP:  mul_c = svf_pkg::COEF_W'(damp_q);
			svf_pkg::MC_SCALE: mul_c = svf_pkg::COEF_W'(scale_q);
			default:           mul_c = freq_q;
		endcase
	end

	assign mul_neg  = mul_a[svf_pkg::STATE_BITS-1];
	// the most negative value maps to its true magnitude as unsigned
	assign mul_mag  = mul_neg ? svf_pkg::STATE_BITS'(-mul_a) : svf_pkg::STATE_BITS'(mul_a);
	assign mul_prod = svf_pkg::PROD_W'(mul_mag) * svf_pkg::PROD_W'(mul_c) + MUL_HALF;

	// ------------------------------------------------------------------
	// adder: signed product against a state, then clamp to state range
	// ------------------------------------------------------------------
	assign m_val = mneg_q ? -$signed(svf_pkg::ACC_W'(mres_q))
	                      :  $signed(svf_pkg::ACC_W'(mres_q));

	always_comb begin
		case (uc.alu_a)
			svf_pkg::AA_LOW:  alu_a = svf_pkg::ACC_W'(low_q);
			svf_pkg::AA_MUL:  alu_a = m_val;
			svf_pkg::AA_ACC:  alu_a = acc_q;
			svf_pkg::AA_HP:   alu_a = svf_pkg::ACC_W'(hp_q);
			svf_pkg::AA_BAND: alu_a = svf_pkg::ACC_W'(band_q);
			default:          alu_a = svf_pkg::ACC_W'(low_q);
		endcase
		case (uc.alu_b)
			svf_pkg::AB_MUL: alu_b = m_val;
			svf_pkg::AB_LOW: alu_b = svf_pkg::ACC_W'(low_q);
			default:         alu_b = m_val;
		endcase
	end

	assign alu_sum = uc.alu_sub ? alu_a - alu_b : alu_a + alu_b;

	always_comb begin
		if (alu_sum > svf_pkg::SAT_MAX) begin
			alu_sat = svf_pkg::STATE_BITS'(svf_pkg::SAT_MAX);
		end else if (alu_sum < svf_pkg::SAT_MIN) begin
			alu_sat = svf_pkg::STATE_BITS'(svf_pkg::SAT_MIN);
		end else begin
			alu_sat = svf_pkg::STATE_BITS'(alu_sum);
		end
	end

	// ------------------------------------------------------------------
	// output: pick the response, drop the guard bits with rounding
	// ------------------------------------------------------------------
	always_comb begin
		case (mode_q)
			svf_pkg::MODE_LP:    sel_v = low_q;
			svf_pkg::MODE_BP:    sel_v = band_q;
			svf_pkg::MODE_HP:    sel_v = hp_q;
			svf_pkg::MODE_NOTCH: sel_v = nt_q;
			default:             sel_v = low_q;
		endcase
	end

	assign sel_neg = sel_v[svf_pkg::STATE_BITS-1];
	assign sel_mag = sel_neg ? svf_pkg::STATE_BITS'(-sel_v) : svf_pkg::STATE_BITS'(sel_v);
	assign rnd_sum = {1'b0, sel_mag} + OUT_HALF;
	assign rnd     = rnd_sum[svf_pkg::STATE_BITS:svf_pkg::GUARD_BITS];

	always_comb begin
		if (sel_neg) begin
			if (rnd >= SMP_LIM) begin
				sample_d = SMP_MIN;
			end else begin
				sample_d = -$signed(rnd[svf_pkg::SAMPLE_BITS-1:0]);
			end
		end else begin
			if (rnd >= SMP_LIM) begin
				sample_d = SMP_MAX;
			end else begin
				sample_d = $signed(rnd[svf_pkg::SAMPLE_BITS-1:0]);
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = sample_q;

	// ------------------------------------------------------------------
	// control state, configuration and filter state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= svf_pkg::STEP_WAIT;
			out_valid_q <= 1'b0;
			freq_q      <= svf_pkg::FREQ_RESET;
			damp_q      <= svf_pkg::DAMP_RESET;
			scale_q     <= svf_pkg::SCALE_RESET;
			mode_q      <= svf_pkg::MODE_LP;
			low_q       <= '0;
			band_q      <= '0;
		end else begin
			if (advance) begin
				step_q <= uc.next_step;
			end

			if (uc.out_load && advance) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_idx)
					svf_pkg::REG_FREQ:  freq_q  <= cfg_data[svf_pkg::FREQ_W-1:0];
					svf_pkg::REG_DAMP:  damp_q  <= cfg_data[svf_pkg::DAMP_W-1:0];
					svf_pkg::REG_SCALE: scale_q <= cfg_data[svf_pkg::SCALE_W-1:0];
					svf_pkg::REG_MODE:  mode_q  <= cfg_data[svf_pkg::MODE_W-1:0];
					default: ;
				endcase
			end

			case (uc.dest)
				svf_pkg::DST_LOW:  low_q  <= alu_sat;
				svf_pkg::DST_BAND: band_q <= alu_sat;
				default: ;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		mres_q <= mul_prod[svf_pkg::PROD_W-1:svf_pkg::COEF_FRAC_BITS];
		mneg_q <= mul_neg;

		if (in_acc) begin
			x_q <= in_ch.sample_in;
		end

		case (uc.dest)
			svf_pkg::DST_ACC: acc_q <= alu_sum;
			svf_pkg::DST_HP:  hp_q  <= alu_sat;
			svf_pkg::DST_NT:  nt_q  <= alu_sat;
			default: ;
		endcase

		if (uc.out_load && advance) begin
			sample_q <= sample_d;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// an accepted item always starts the program at its first work step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (step_q == svf_pkg::STEP_LOW))
		else $error("accepted item did not start the program");

	// filter state only moves on the two steps that update it
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != svf_pkg::STEP_LOW && step_q != svf_pkg::STEP_BAND)
		|=> ($stable(low_q) && $stable(band_q)))
		else $error("filter state changed outside its update steps");

	// a new result only appears from the output step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(step_q) == svf_pkg::STEP_OUT))
		else $error("output valid rose outside the output step");

	// the output step never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !(uc.out_load && advance))
		else $error("pending result overwritten");

endmodule
